// ===== design/lsvm_pkg.sv =====
// shared types, codes and helpers for the looped sample voice mixer
package lsvm_pkg;

   // command codes
   localparam logic [1:0] CMD_WRITE = 2'd0;
   localparam logic [1:0] CMD_START = 2'd1;
   localparam logic [1:0] CMD_MIX   = 2'd2;

   // register indexes
   localparam logic [1:0] REG_CLIP_LENGTH  = 2'd0;
   localparam logic [1:0] REG_LOOP_START   = 2'd1;
   localparam logic [1:0] REG_LOOP_END     = 2'd2;
   localparam logic [1:0] REG_LOOP_ENABLED = 2'd3;

   localparam int CMD_W    = 2;
   localparam int ADDR_W   = 16;
   localparam int SAMPLE_W = 16;
   localparam int FRAME_W  = 2 * SAMPLE_W;
   localparam int REG_W    = 17;
   localparam int IDX_W    = 2;
   localparam int LPTR_W   = 16;

   localparam int QUEUE_DEPTH = 4;

   // cycles the front waits for the derived loop bounds after a change
   localparam logic [1:0] SETTLE_CYCLES = 2'd2;

   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

   typedef struct packed {
      logic is_write;
      logic active;
   } q_ctrl_type;

   localparam int CTRL_W = $bits(q_ctrl_type);

   function automatic logic signed [SAMPLE_W-1:0] sat_add16(
      input logic signed [SAMPLE_W-1:0] a,
      input logic signed [SAMPLE_W-1:0] b);
      logic signed [SAMPLE_W:0] sum;
      sum = {a[SAMPLE_W-1], a} + {b[SAMPLE_W-1], b};
      // the two top bits differ only when the sum left the 16-bit range
      if (sum[SAMPLE_W] != sum[SAMPLE_W-1]) begin
         return sum[SAMPLE_W] ? SAMPLE_MIN : SAMPLE_MAX;
      end else begin
         return sum[SAMPLE_W-1:0];
      end
   endfunction

endpackage

// ===== design/lsvm_front.sv =====
// front end: registers, command decode and voice sequencing
module lsvm_front import lsvm_pkg::*; #(
   parameter int CLIP_DEPTH    = 65536,
   parameter int DURATION_BITS = 24,
   parameter int AW            = $clog2(CLIP_DEPTH),
   parameter int QW            = CTRL_W + AW + FRAME_W
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CMD_W-1:0]           req_command,
   input  logic [ADDR_W-1:0]          req_address,
   input  logic signed [SAMPLE_W-1:0] req_sample_left,
   input  logic signed [SAMPLE_W-1:0] req_sample_right,
   input  logic [DURATION_BITS-1:0]   req_hold_frames,
   input  logic signed [SAMPLE_W-1:0] req_acc_left,
   input  logic signed [SAMPLE_W-1:0] req_acc_right,
   input  logic                       csr_we,
   input  logic [IDX_W-1:0]           csr_index,
   input  logic [REG_W-1:0]           csr_wdata,
   output logic                       q_push,
   output logic [QW-1:0]              q_data,
   input  logic                       q_full
);

   localparam int DB = DURATION_BITS;
   localparam int W  = ((DB > REG_W) ? DB : REG_W) + 1;

   logic [REG_W-1:0] clip_length_ff, loop_start_ff, loop_end_ff;
   logic             loop_enabled_ff;

   logic [DB-1:0]     dur_ff, pos_ff, pos_in, dur_in;
   logic [LPTR_W-1:0] lptr_ff, lptr_in;
   logic              running_ff, running_in;
   logic [1:0]        settle_ff;

   // derived loop bounds, two register stages
   logic [REG_W-1:0] len_ff, len_in;
   logic             order_ok_ff, order_ok_in;
   logic             looping_ff, looping_in;
   logic [W-1:0]     rel_start_ff, rel_start_in;
   logic [W-1:0]     rel_off_ff, rel_off_in;

   logic         accept, is_write, is_start, is_mix, wr_in_range;
   logic         due;
   logic [W-1:0] pos_w, idx_w, ls_w, le_w;
   logic [REG_W-1:0] lp_cur, lp_inc;
   q_ctrl_type   ctrl;

   assign req_stall = (settle_ff != 2'd0) || q_full;
   assign accept    = req_valid && !req_stall;
   assign is_write  = (req_command == CMD_WRITE);
   assign is_start  = (req_command == CMD_START);
   assign is_mix    = (req_command == CMD_MIX);
   assign wr_in_range = (32'(req_address) < 32'(CLIP_DEPTH));

   // stage one of the derived bounds
   always_comb begin
      len_in = (32'(clip_length_ff) > 32'(CLIP_DEPTH)) ? REG_W'(CLIP_DEPTH) : clip_length_ff;
      order_ok_in = loop_enabled_ff && (loop_start_ff < loop_end_ff);
   end

   // stage two: looping decision and release bounds for the current duration
   always_comb begin
      looping_in = order_ok_ff && (loop_end_ff <= len_ff) &&
                   !(W'(dur_ff) <= (W'(loop_start_ff) + W'(len_ff) - W'(loop_end_ff)));
      rel_start_in = W'(dur_ff) + W'(loop_end_ff) - W'(len_ff);
      rel_off_in   = W'(dur_ff) - W'(len_ff);
   end

   assign pos_w = W'(pos_ff);
   assign ls_w  = W'(loop_start_ff);
   assign le_w  = W'(loop_end_ff);

   // frame selection for a mix
   always_comb begin
      due     = 1'b0;
      idx_w   = pos_w;
      lp_cur  = REG_W'(lptr_ff);
      lp_inc  = '0;
      lptr_in = lptr_ff;
      if (!looping_ff) begin
         due = (pos_w < W'(len_ff));
      end else if (pos_w < ls_w) begin
         due = 1'b1;
      end else if (pos_w >= rel_start_ff) begin
         due   = 1'b1;
         idx_w = pos_w - rel_off_ff;
      end else begin
         due = 1'b1;
         if ((pos_w == ls_w) || (REG_W'(lptr_ff) < loop_start_ff) ||
             (REG_W'(lptr_ff) >= loop_end_ff)) begin
            lp_cur = loop_start_ff;
         end
         idx_w  = W'(lp_cur);
         lp_inc = lp_cur + REG_W'(1);
         lptr_in = (lp_inc >= loop_end_ff) ? LPTR_W'(loop_start_ff) : LPTR_W'(lp_inc);
      end
   end

   always_comb begin
      pos_in     = pos_ff;
      dur_in     = dur_ff;
      running_in = running_ff;
      q_push     = 1'b0;
      ctrl.is_write = is_write;
      ctrl.active   = 1'b0;
      q_data = {ctrl, AW'(req_address), req_sample_right, req_sample_left};
      if (accept) begin
         if (is_write) begin
            q_push = wr_in_range;
         end else if (is_start) begin
            dur_in     = req_hold_frames;
            pos_in     = '0;
            running_in = (req_hold_frames != '0);
         end else if (is_mix) begin
            q_push = 1'b1;
            if (running_ff) begin
               ctrl.active = due;
               pos_in      = pos_ff + DB'(1);
               running_in  = ((pos_ff + DB'(1)) < dur_ff);
            end
            q_data = {ctrl, AW'(idx_w), req_acc_right, req_acc_left};
         end
      end
   end

   always_ff @(posedge clock) begin
      len_ff       <= len_in;
      order_ok_ff  <= order_ok_in;
      looping_ff   <= looping_in;
      rel_start_ff <= rel_start_in;
      rel_off_ff   <= rel_off_in;
      if (reset) begin
         clip_length_ff  <= '0;
         loop_start_ff   <= '0;
         loop_end_ff     <= '0;
         loop_enabled_ff <= 1'b0;
         dur_ff          <= '0;
         pos_ff          <= '0;
         lptr_ff         <= '0;
         running_ff      <= 1'b0;
         settle_ff       <= SETTLE_CYCLES;
      end else begin
         if (csr_we) begin
            case (csr_index)
               REG_CLIP_LENGTH:  clip_length_ff  <= csr_wdata;
               REG_LOOP_START:   loop_start_ff   <= csr_wdata;
               REG_LOOP_END:     loop_end_ff     <= csr_wdata;
               REG_LOOP_ENABLED: loop_enabled_ff <= csr_wdata[0];
               default:          ;
            endcase
         end
         dur_ff     <= dur_in;
         pos_ff     <= pos_in;
         running_ff <= running_in;
         if (accept && is_start) begin
            lptr_ff <= '0;
         end else if (accept && is_mix && running_ff) begin
            lptr_ff <= lptr_in;
         end
         if (csr_we || (accept && is_start)) begin
            settle_ff <= SETTLE_CYCLES;
         end else if (settle_ff != 2'd0) begin
            settle_ff <= settle_ff - 2'd1;
         end
      end
   end

endmodule

// ===== design/lsvm_queue.sv =====
// short fifo between front and back
module lsvm_queue import lsvm_pkg::*; #(
   parameter int QW = 8
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  logic [QW-1:0] push_data,
   output logic          full,
   input  logic          pop,
   output logic          not_empty,
   output logic [QW-1:0] head_data
);

   localparam int PW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [QW-1:0] entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CW-1:0] count_ff;

   assign full      = (count_ff == CW'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head_data = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule

// ===== design/lsvm_back.sv =====
// back end: clip store, read stage and saturating mix output register
module lsvm_back import lsvm_pkg::*; #(
   parameter int CLIP_DEPTH = 65536,
   parameter int AW         = $clog2(CLIP_DEPTH),
   parameter int QW         = CTRL_W + AW + FRAME_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        q_not_empty,
   input  logic [QW-1:0]               q_head,
   output logic                        q_pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SAMPLE_W-1:0]  rsp_mix_left,
   output logic signed [SAMPLE_W-1:0]  rsp_mix_right,
   output logic                        rsp_voice_active
);

   logic [FRAME_W-1:0] clip_mem [CLIP_DEPTH];

   q_ctrl_type         head_ctrl;
   logic [AW-1:0]      head_addr;
   logic [FRAME_W-1:0] head_frame;

   logic               s1_valid_ff;
   logic [FRAME_W-1:0] s1_rd_ff, s1_acc_ff;
   logic               s1_active_ff;
   logic               out_valid_ff;

   logic s1_move, s1_load, mem_we;
   logic signed [SAMPLE_W-1:0] clip_l, clip_r;

   assign {head_ctrl, head_addr, head_frame} = q_head;

   assign s1_move = s1_valid_ff && (!out_valid_ff || !rsp_stall);
   assign s1_load = q_not_empty && !head_ctrl.is_write && (!s1_valid_ff || s1_move);
   assign mem_we  = q_not_empty && head_ctrl.is_write;
   assign q_pop   = mem_we || s1_load;

   assign clip_l = s1_active_ff ? s1_rd_ff[SAMPLE_W-1:0] : '0;
   assign clip_r = s1_active_ff ? s1_rd_ff[FRAME_W-1:SAMPLE_W] : '0;

   assign rsp_valid = out_valid_ff;

   // clip store
   always_ff @(posedge clock) begin
      if (mem_we) begin
         clip_mem[head_addr] <= head_frame;
      end
      if (s1_load) begin
         s1_rd_ff <= clip_mem[head_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (s1_load) begin
         s1_acc_ff    <= head_frame;
         s1_active_ff <= head_ctrl.active;
      end
      if (s1_move) begin
         rsp_mix_left     <= sat_add16(s1_acc_ff[SAMPLE_W-1:0], clip_l);
         rsp_mix_right    <= sat_add16(s1_acc_ff[FRAME_W-1:SAMPLE_W], clip_r);
         rsp_voice_active <= s1_active_ff;
      end
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (s1_load) begin
            s1_valid_ff <= 1'b1;
         end else if (s1_move) begin
            s1_valid_ff <= 1'b0;
         end
         if (s1_move) begin
            out_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== design/looped_sample_voice_mixer_core.sv =====
// top level of the looped sample voice mixer
//
// single-voice sample player: write transactions fill the clip store, a start
// transaction arms the voice for a duration, and every mix transaction returns
// one accumulator frame with the due clip frame added and saturated per channel.
// the front decodes transactions and works out which clip frame is due (intro,
// repeated body, release, or a plain truncated play when looping is off or the
// loop registers are inconsistent); the back holds the clip store, reads it and
// does the saturating add. a four-entry queue sits between them, so a stalled
// result side does not stop the front until the queue fills. steady state is one
// transaction per clock unless a full queue or the settling stall holds it; a mix
// result passes the queue entry, the store read register and the output register
// before it is offered. the loop bounds are derived in two register stages from
// the control registers and the duration, so the input side stalls after every
// register write and every start transaction while the bounds settle. write and
// start transactions give no result; command code 3 is dropped. the clip store
// has no clearing pass and no valid bits: reading a frame that was never
// written gives whatever the store holds.
module looped_sample_voice_mixer_core import lsvm_pkg::*; #(
   parameter int CLIP_DEPTH    = 65536,
   parameter int DURATION_BITS = 24
) (
   input  logic                       clock,
   input  logic                       reset,
   // input transactions
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [CMD_W-1:0]           req_command,
   input  logic [ADDR_W-1:0]          req_address,
   input  logic signed [SAMPLE_W-1:0] req_sample_left,
   input  logic signed [SAMPLE_W-1:0] req_sample_right,
   input  logic [DURATION_BITS-1:0]   req_hold_frames,
   input  logic signed [SAMPLE_W-1:0] req_acc_left,
   input  logic signed [SAMPLE_W-1:0] req_acc_right,
   // result transactions
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic signed [SAMPLE_W-1:0] rsp_mix_left,
   output logic signed [SAMPLE_W-1:0] rsp_mix_right,
   output logic                       rsp_voice_active,
   // control registers
   input  logic                       csr_we,
   input  logic [IDX_W-1:0]           csr_index,
   input  logic [REG_W-1:0]           csr_wdata
);

   localparam int AW = $clog2(CLIP_DEPTH);
   localparam int QW = CTRL_W + AW + FRAME_W;

   logic          q_push, q_full, q_pop, q_not_empty;
   logic [QW-1:0] q_push_data, q_head;

   // decode and voice sequencing
   lsvm_front #(
      .CLIP_DEPTH    (CLIP_DEPTH),
      .DURATION_BITS (DURATION_BITS),
      .AW            (AW),
      .QW            (QW)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_address      (req_address),
      .req_sample_left  (req_sample_left),
      .req_sample_right (req_sample_right),
      .req_hold_frames  (req_hold_frames),
      .req_acc_left     (req_acc_left),
      .req_acc_right    (req_acc_right),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .q_push           (q_push),
      .q_data           (q_push_data),
      .q_full           (q_full)
   );

   // decoupling queue
   lsvm_queue #(
      .QW (QW)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head_data (q_head)
   );

   // clip store and mixing
   lsvm_back #(
      .CLIP_DEPTH (CLIP_DEPTH),
      .AW         (AW),
      .QW         (QW)
   ) u_back (
      .clock            (clock),
      .reset            (reset),
      .q_not_empty      (q_not_empty),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mix_left     (rsp_mix_left),
      .rsp_mix_right    (rsp_mix_right),
      .rsp_voice_active (rsp_voice_active)
   );

   // derived loop bounds must settle before the next transaction is taken
   a_settle_after_csr: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !(req_valid && !req_stall))
      else $error("transaction taken before loop bounds settled");

   // the front never pushes into a full queue
   a_no_queue_overflow: assert property (@(posedge clock) disable iff (reset)
      q_full |-> !q_push)
      else $error("push into full queue");

   // the back only pops what the queue holds
   a_no_queue_underflow: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_not_empty)
      else $error("pop from empty queue");

endmodule

// ===== tb/sv/looped_sample_voice_mixer_core_test.sv =====
// self-checking testbench for the looped sample voice mixer core
module looped_sample_voice_mixer_core_test;
   import lsvm_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int          CLK_PERIOD   = 10;
   localparam int          STORE_DEPTH  = 65536;
   localparam int          HOLD_W       = 24;
   localparam longint      HOLD_MAX     = 64'hFF_FFFF;
   localparam int          ITEMS_TOTAL  = 850;
   localparam int          SETTING_SPAN = 60;    // transactions between register changes
   localparam int          DRAIN_CYCLES = 10;    // queue, store read and output register, plus margin
   localparam int          STALL_LIMIT  = 4000;  // cycles with no transaction before giving up
   // command code the block drops without a result
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   // one input transaction, every field carried whatever the command
   typedef struct {
      logic [CMD_W-1:0]           command;
      logic [ADDR_W-1:0]          address;
      logic signed [SAMPLE_W-1:0] sample_left;
      logic signed [SAMPLE_W-1:0] sample_right;
      logic [HOLD_W-1:0]          hold;
      logic signed [SAMPLE_W-1:0] acc_left;
      logic signed [SAMPLE_W-1:0] acc_right;
   } voice_req_type;

   // one mixed output frame
   typedef struct {
      logic signed [SAMPLE_W-1:0] left;
      logic signed [SAMPLE_W-1:0] right;
      logic                       active;
   } mix_frame_type;

   // voice predictor plus the queue of mixed frames still owed by the block
   class voice_scoreboard_type;
      logic [FRAME_W-1:0] clip_mem [int];
      int unsigned        play_pos;
      int unsigned        loop_ptr;
      int unsigned        hold_len;
      bit                 running;
      int unsigned        clip_len;
      int unsigned        loop_first;
      int unsigned        loop_stop;
      bit                 loop_on;
      mix_frame_type      due_mixes[$];
      int                 errors;
      int                 results_seen;

      function void set_reg(logic [IDX_W-1:0] idx, logic [REG_W-1:0] val);
         case (idx)
            REG_CLIP_LENGTH:  clip_len   = val;
            REG_LOOP_START:   loop_first = val;
            REG_LOOP_END:     loop_stop  = val;
            REG_LOOP_ENABLED: loop_on    = val[0];
            default: ;
         endcase
      endfunction

      // clip lengths past the store size count as the full store
      function int unsigned eff_len();
         return (clip_len > STORE_DEPTH) ? STORE_DEPTH : clip_len;
      endfunction

      // which clip frame is due at position p; the loop pointer moves only on commit
      function bit clip_frame_due(int unsigned p, bit commit, output int unsigned idx);
         longint unsigned len, intro, tail, dur;
         int unsigned     lp;
         bit              looping;
         len     = eff_len();
         dur     = hold_len;
         intro   = 0;
         tail    = 0;
         idx     = 0;
         looping = loop_on && loop_first < loop_stop && loop_stop <= len;
         if (looping) begin
            intro = loop_first;
            tail  = len - loop_stop;
            // too short to reach the body: plain truncated play
            if (dur <= intro + tail) looping = 0;
         end
         if (!looping) begin
            if (p < len) begin
               idx = p;
               return 1;
            end
            return 0;
         end
         if (p < intro) begin
            idx = p;
            return 1;
         end
         if (p >= dur - tail) begin
            idx = loop_stop + (p - (dur - tail));
            return 1;
         end
         lp = loop_ptr;
         if (p == intro || lp < loop_first || lp >= loop_stop) lp = loop_first;
         idx = lp;
         if (commit) begin
            loop_ptr = lp + 1;
            if (loop_ptr >= loop_stop) loop_ptr = loop_first;
         end
         return 1;
      endfunction

      // frame the next mix would read, without moving any state
      function bit next_read(output int unsigned idx);
         idx = 0;
         if (!running || play_pos >= hold_len) return 0;
         return clip_frame_due(play_pos, 0, idx) && idx < STORE_DEPTH;
      endfunction

      function logic signed [SAMPLE_W-1:0] clamp16(int s);
         if (s > int'(SAMPLE_MAX)) return SAMPLE_MAX;
         if (s < int'(SAMPLE_MIN)) return SAMPLE_MIN;
         return s[SAMPLE_W-1:0];
      endfunction

      // called for every accepted input transaction
      function void take_command(voice_req_type r);
         mix_frame_type      want;
         int unsigned        idx;
         logic [FRAME_W-1:0] frame;
         int                 cl, cr;
         case (r.command)
            CMD_WRITE: clip_mem[r.address] = {r.sample_right, r.sample_left};
            CMD_START: begin
               hold_len = r.hold;
               play_pos = 0;
               loop_ptr = 0;
               running  = (hold_len != 0);
            end
            CMD_MIX: begin
               cl          = 0;
               cr          = 0;
               want.active = 1'b0;
               if (running) begin
                  if (play_pos >= hold_len) begin
                     running = 0;
                  end else begin
                     if (clip_frame_due(play_pos, 1, idx) && idx < STORE_DEPTH) begin
                        frame       = clip_mem.exists(idx) ? clip_mem[idx] : '0;
                        cl          = $signed(frame[SAMPLE_W-1:0]);
                        cr          = $signed(frame[FRAME_W-1:SAMPLE_W]);
                        want.active = 1'b1;
                     end
                     play_pos++;
                     if (play_pos >= hold_len) running = 0;
                  end
               end
               want.left  = clamp16(int'(r.acc_left) + cl);
               want.right = clamp16(int'(r.acc_right) + cr);
               due_mixes  = {due_mixes, want};
            end
            default: ;
         endcase
      endfunction

      // called for every accepted result transaction
      function void check_mix(logic signed [SAMPLE_W-1:0] left, logic signed [SAMPLE_W-1:0] right,
                              logic active);
         mix_frame_type want;
         if (due_mixes.size() == 0) begin
            $error("result with no mix waiting: mix_left %0d mix_right %0d voice_active %0b",
                   left, right, active);
            errors++;
            return;
         end
         want = due_mixes.pop_front();
         results_seen++;
         if (left !== want.left) begin
            $error("mix_left: expected %0d, got %0d", want.left, left);
            errors++;
         end
         if (right !== want.right) begin
            $error("mix_right: expected %0d, got %0d", want.right, right);
            errors++;
         end
         if (active !== want.active) begin
            $error("voice_active: expected %0b, got %0b", want.active, active);
            errors++;
         end
      endfunction
   endclass

   // clock, reset and block inputs, all known from time zero
   logic                       clock            = 1'b0;
   logic                       reset            = 1'b1;
   logic                       req_valid        = 1'b0;
   logic                       req_stall;
   logic [CMD_W-1:0]           req_command      = CMD_UNUSED;
   logic [ADDR_W-1:0]          req_address      = '0;
   logic signed [SAMPLE_W-1:0] req_sample_left  = '0;
   logic signed [SAMPLE_W-1:0] req_sample_right = '0;
   logic [HOLD_W-1:0]          req_hold_frames  = '0;
   logic signed [SAMPLE_W-1:0] req_acc_left     = '0;
   logic signed [SAMPLE_W-1:0] req_acc_right    = '0;
   logic                       rsp_valid;
   logic                       rsp_stall        = 1'b0;
   logic signed [SAMPLE_W-1:0] rsp_mix_left;
   logic signed [SAMPLE_W-1:0] rsp_mix_right;
   logic                       rsp_voice_active;
   logic                       csr_we           = 1'b0;
   logic [IDX_W-1:0]           csr_index        = REG_CLIP_LENGTH;
   logic [REG_W-1:0]           csr_wdata        = '0;

   voice_scoreboard_type sb = new();

   int send_idle_pct  = 23;   // chance the sender holds off before a transaction
   int stall_pct      = 48;   // chance the result side stalls in a cycle
   int idle_cycles    = 0;    // cycles since any transaction moved
   int issued         = 0;    // accepted transactions the block acts on
   int settings_used  = 0;

   looped_sample_voice_mixer_core #(
      .CLIP_DEPTH    (STORE_DEPTH),
      .DURATION_BITS (HOLD_W)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_command      (req_command),
      .req_address      (req_address),
      .req_sample_left  (req_sample_left),
      .req_sample_right (req_sample_right),
      .req_hold_frames  (req_hold_frames),
      .req_acc_left     (req_acc_left),
      .req_acc_right    (req_acc_right),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mix_left     (rsp_mix_left),
      .rsp_mix_right    (rsp_mix_right),
      .rsp_voice_active (rsp_voice_active),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // result side: check what was taken at this edge, then pick the next stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall   <= 1'b0;
         idle_cycles <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            sb.check_mix(rsp_mix_left, rsp_mix_right, rsp_voice_active);
         end
         rsp_stall <= ($urandom_range(99) < stall_pct);
         // progress watchdog: any transaction or register write resets the count
         if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || csr_we) begin
            idle_cycles <= 0;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   initial begin
      wait (idle_cycles >= STALL_LIMIT);
      $error("no transaction moved for %0d cycles, %0d mixes outstanding",
             STALL_LIMIT, sb.due_mixes.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // mostly random samples, with the rails now and then to force saturation
   function automatic logic signed [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(7))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         default: return $urandom;
      endcase
   endfunction

   // unused fields carry random values so every port bit toggles
   function automatic voice_req_type make_req(logic [CMD_W-1:0] cmd);
      voice_req_type r;
      r.command      = cmd;
      r.address      = $urandom;
      r.sample_left  = $urandom;
      r.sample_right = $urandom;
      r.hold         = $urandom;
      r.acc_left     = $urandom;
      r.acc_right    = $urandom;
      return r;
   endfunction

   // present one transaction and wait for the block to take it; valid stays up
   // afterwards so back-to-back transactions need no extra edge
   task automatic send_cmd(input voice_req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_command      <= r.command;
      req_address      <= r.address;
      req_sample_left  <= r.sample_left;
      req_sample_right <= r.sample_right;
      req_hold_frames  <= r.hold;
      req_acc_left     <= r.acc_left;
      req_acc_right    <= r.acc_right;
      do @(posedge clock); while (req_stall);
      sb.take_command(r);
      if (r.command != CMD_UNUSED) issued++;
   endtask

   task automatic put_frame(input logic [ADDR_W-1:0] addr,
                            input logic signed [SAMPLE_W-1:0] left,
                            input logic signed [SAMPLE_W-1:0] right);
      voice_req_type r;
      r              = make_req(CMD_WRITE);
      r.address      = addr;
      r.sample_left  = left;
      r.sample_right = right;
      send_cmd(r);
   endtask

   task automatic start_voice(input longint unsigned frames);
      voice_req_type r;
      r      = make_req(CMD_START);
      r.hold = (frames > HOLD_MAX) ? HOLD_MAX : frames;
      send_cmd(r);
   endtask

   // a clip frame that is about to be read but was never stored gets written first
   task automatic mix_frame(input logic signed [SAMPLE_W-1:0] left,
                            input logic signed [SAMPLE_W-1:0] right);
      voice_req_type r;
      int unsigned   idx;
      if (sb.next_read(idx) && !sb.clip_mem.exists(idx)) begin
         put_frame(idx[ADDR_W-1:0], pick_sample(), pick_sample());
      end
      r           = make_req(CMD_MIX);
      r.acc_left  = left;
      r.acc_right = right;
      send_cmd(r);
   endtask

   task automatic send_noise();
      send_cmd(make_req(CMD_UNUSED));
   endtask

   // let every owed mix come back, then give trailing writes and starts time to land
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.due_mixes.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [REG_W-1:0] val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
   endtask

   // block must be idle: called only after reset or after settle
   task automatic program_regs(input logic [REG_W-1:0] len, input logic [REG_W-1:0] first,
                               input logic [REG_W-1:0] stop, input logic enable);
      write_reg(REG_CLIP_LENGTH, len);
      write_reg(REG_LOOP_START, first);
      write_reg(REG_LOOP_END, stop);
      write_reg(REG_LOOP_ENABLED, {{(REG_W-1){1'b0}}, enable});
      csr_we <= 1'b0;
      settings_used++;
   endtask

   // fixed corner settings first, random small clips afterwards
   task automatic apply_setting(input int k);
      int unsigned len, first, stop;
      case (k)
         0: program_regs(12, 3, 7, 1'b1);                 // ordinary intro, body, release
         1: program_regs(0, 0, 0, 1'b0);                  // empty clip
         2: program_regs(17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 1'b1); // all at maximum
         3: program_regs(65536, 0, 65536, 1'b1);          // whole clip is the body
         4: program_regs(10, 6, 6, 1'b1);                 // zero-length body
         5: program_regs(10, 7, 3, 1'b1);                 // body bounds reversed
         6: program_regs(10, 2, 11, 1'b1);                // body runs past the clip end
         7: program_regs(16, 4, 9, 1'b0);                 // looping switched off
         8: program_regs(65536, 0, 1, 1'b1);              // one-frame body, long release
         default: begin
            len   = $urandom_range(1, 24);
            stop  = $urandom_range(1, len);
            first = $urandom_range(0, stop - 1);
            if ($urandom_range(5) == 0) stop = $urandom_range(0, len + 2);
            program_regs(len, first, stop, $urandom_range(3) != 0);
         end
      endcase
   endtask

   // one start followed by a run of mixes, durations placed around the loop boundary
   task automatic voice_burst();
      longint unsigned len_eff, tail, base, dur;
      int              n;
      len_eff = sb.eff_len();
      tail    = (sb.loop_stop <= len_eff) ? len_eff - sb.loop_stop : 0;
      base    = sb.loop_first + tail;
      case ($urandom_range(9))
         0:       dur = 0;
         1:       dur = base;                         // longest truncated play
         2:       dur = base + 1;                     // shortest looped play
         3, 4:    dur = base + $urandom_range(2, 40);
         5:       dur = $urandom_range(1, len_eff + 4);
         6:       dur = $urandom & HOLD_MAX;
         7:       dur = HOLD_MAX;
         default: dur = $urandom_range(1, 30);
      endcase
      if (dur > HOLD_MAX) dur = HOLD_MAX;
      start_voice(dur);
      // short voices run to their end and a little past; long ones get cut by a restart
      n = (dur <= 80) ? int'(dur) + $urandom_range(0, 3) : $urandom_range(1, 40);
      repeat (n) begin
         case ($urandom_range(19))
            0: put_frame($urandom_range(0, 1) ? $urandom : $urandom_range(0, 31),
                         pick_sample(), pick_sample());
            1: send_noise();
            default: mix_frame(pick_sample(), pick_sample());
         endcase
      end
   endtask

   initial begin
      int next_switch;
      int k;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part: intro of two frames, three-frame body, release of three
      program_regs(8, 2, 5, 1'b1);
      send_noise();
      put_frame(16'h0000, SAMPLE_MAX, SAMPLE_MIN);
      put_frame(16'hFFFF, SAMPLE_MIN, SAMPLE_MAX);
      mix_frame(SAMPLE_MAX, SAMPLE_MIN);              // idle voice passes through
      start_voice(0);                                 // zero duration leaves it stopped
      mix_frame(0, 0);
      start_voice(HOLD_MAX);
      mix_frame(SAMPLE_MAX, SAMPLE_MIN);              // both channels hit the rails
      mix_frame(SAMPLE_MIN, SAMPLE_MAX);
      mix_frame(0, 0);
      start_voice(7);                                 // restart while playing, just loops
      repeat (8) mix_frame(pick_sample(), pick_sample());

      // random part, idling pattern changes by thirds
      k           = 0;
      next_switch = issued;
      while (issued < ITEMS_TOTAL) begin
         if (issued >= next_switch) begin
            settle();
            apply_setting(k);
            k++;
            next_switch = issued + SETTING_SPAN;
         end
         if (issued < ITEMS_TOTAL / 3) begin
            send_idle_pct = 23;
            stall_pct     = 48;
         end else if (issued < 2 * ITEMS_TOTAL / 3) begin
            send_idle_pct = 48;
            stall_pct     = 23;
         end else begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
         if ($urandom_range(9) == 0) begin
            mix_frame(pick_sample(), pick_sample());  // stray mix, voice may be idle
         end else begin
            voice_burst();
         end
      end

      settle();
      $display("run covered %0d transactions and %0d checked mixes over %0d register settings",
               issued, sb.results_seen, settings_used);
      if (sb.errors == 0 && sb.due_mixes.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
design/lsvm_pkg.sv
design/lsvm_front.sv
design/lsvm_queue.sv
design/lsvm_back.sv
design/looped_sample_voice_mixer_core.sv
tb/sv/looped_sample_voice_mixer_core_test.sv
